// ===== hdl/rgbhs_pkg.sv =====
package rgbhs_pkg;

  // Configuration register widths and indexes
  localparam int unsigned REG_W  = 13;
  localparam int unsigned ROW_W  = 12;
  localparam int unsigned LANE_W = 9;

  localparam logic [REG_W-1:0] HEIGHT_LIMIT = 13'd4096;
  localparam logic [REG_W-1:0] DIM_MIN      = 13'd2;
  localparam logic [REG_W-1:0] WIDTH_RESET  = 13'd640;
  localparam logic [REG_W-1:0] HEIGHT_RESET = 13'd480;

  typedef enum logic [0:0] {
    REG_FRAME_WIDTH  = 1'b0,
    REG_FRAME_HEIGHT = 1'b1
  } reg_idx_e;

  // Three 9-bit lane sums; blue on top, red at the bottom
  typedef struct packed {
    logic [LANE_W-1:0] blue;
    logic [LANE_W-1:0] green;
    logic [LANE_W-1:0] red;
  } lane_sum_t;

  // Raster control toward the datapath
  typedef struct packed {
    logic      emit;   // odd row, odd column: output pixel
    logic      store;  // even row, odd column: write pair sum
    logic      last;   // last output pixel of the frame
    lane_sum_t sum;    // horizontal pair sum for this column pair
  } raster_ctrl_t;

endpackage

// ===== hdl/rgbhs_if.sv =====
interface rgbhs_pix_if;
  import rgbhs_pkg::*;
  logic       valid;
  logic       ready;
  logic       start_of_frame;
  logic [7:0] red;
  logic [7:0] green;
  logic [7:0] blue;
  modport source (output valid, start_of_frame, red, green, blue, input ready);
  modport sink   (input valid, start_of_frame, red, green, blue, output ready);
endinterface

interface rgbhs_out_if;
  import rgbhs_pkg::*;
  logic       valid;
  logic       ready;
  logic [7:0] first_byte;
  logic [7:0] middle_byte;
  logic [7:0] third_byte;
  logic       frame_done;
  modport source (output valid, first_byte, middle_byte, third_byte, frame_done,
                  input ready);
  modport sink   (input valid, first_byte, middle_byte, third_byte, frame_done,
                  output ready);
endinterface

interface rgbhs_cfg_if;
  import rgbhs_pkg::*;
  logic             valid;
  logic             ready;
  reg_idx_e         index;
  logic [REG_W-1:0] data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// ===== hdl/rgbhs_line_store.sv =====
module rgbhs_line_store #(
  parameter int unsigned DEPTH = 2048,
  parameter int unsigned AW    = 11
) (
  input  logic                 clk_i,
  input  logic                 wr_en_i,
  input  logic [AW-1:0]        wr_addr_i,
  input  rgbhs_pkg::lane_sum_t wr_data_i,
  input  logic                 rd_en_i,
  input  logic [AW-1:0]        rd_addr_i,
  output rgbhs_pkg::lane_sum_t rd_data_o
);
  import rgbhs_pkg::*;

  lane_sum_t mem [DEPTH];
  lane_sum_t rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
  end

  // Read data holds until the next read
  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_q <= mem[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

// ===== hdl/rgbhs_raster.sv =====
module rgbhs_raster #(
  parameter int unsigned MAX_WIDTH = 4096,
  parameter int unsigned AW        = 11
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         accept_i,
  input  logic                         sof_i,
  input  rgbhs_pkg::lane_sum_t         px_i,
  input  logic [rgbhs_pkg::REG_W-1:0]  frame_width_i,
  input  logic [rgbhs_pkg::REG_W-1:0]  frame_height_i,
  output rgbhs_pkg::raster_ctrl_t      ctrl_o,
  output logic [AW-1:0]                addr_o
);
  import rgbhs_pkg::*;

  localparam int unsigned CW = $clog2(MAX_WIDTH);
  localparam int unsigned WW = $clog2(MAX_WIDTH + 1);

  logic [CW-1:0]    col_q, col_d, col_s, col_p;
  logic [ROW_W-1:0] row_q, row_d, row_s, row_p;
  lane_sum_t        pair_q, pair_d, here;

  logic [WW-1:0]    w_eff, w_last, col_n;
  logic [REG_W-1:0] h_eff, h_last, row_a, row_n;
  logic             wrap_pre;

  // Clamp the configured dimensions
  always_comb begin
    if (frame_width_i < DIM_MIN) begin
      w_eff = WW'(DIM_MIN);
    end else if ({1'b0, frame_width_i} > (REG_W+1)'(MAX_WIDTH)) begin
      w_eff = WW'(MAX_WIDTH);
    end else begin
      w_eff = WW'(frame_width_i);
    end
    if (frame_height_i < DIM_MIN) begin
      h_eff = DIM_MIN;
    end else if (frame_height_i > HEIGHT_LIMIT) begin
      h_eff = HEIGHT_LIMIT;
    end else begin
      h_eff = frame_height_i;
    end
    w_last = {w_eff[WW-1:1], 1'b0} - WW'(1);
    h_last = {h_eff[REG_W-1:1], 1'b0} - REG_W'(1);
  end

  // Position of this pixel, then position of the next one
  always_comb begin
    col_s    = sof_i ? '0 : col_q;
    row_s    = sof_i ? '0 : row_q;
    wrap_pre = WW'(col_s) >= w_eff;
    col_p    = wrap_pre ? '0 : col_s;
    row_a    = wrap_pre ? (REG_W'(row_s) + REG_W'(1)) : REG_W'(row_s);
    row_p    = (row_a >= h_eff) ? '0 : row_a[ROW_W-1:0];

    col_n = WW'(col_p) + WW'(1);
    row_n = REG_W'(row_p) + REG_W'(1);
    if (col_n >= w_eff) begin
      col_d = '0;
      row_d = (row_n >= h_eff) ? '0 : row_n[ROW_W-1:0];
    end else begin
      col_d = col_n[CW-1:0];
      row_d = row_p;
    end
  end

  // Lane-wise pair sum, 9-bit wrap per lane
  always_comb begin
    here.red   = pair_q.red   + px_i.red;
    here.green = pair_q.green + px_i.green;
    here.blue  = pair_q.blue  + px_i.blue;
    pair_d     = col_p[0] ? here : px_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q  <= '0;
      row_q  <= '0;
      pair_q <= '0;
    end else if (accept_i) begin
      col_q  <= col_d;
      row_q  <= row_d;
      pair_q <= pair_d;
    end
  end

  assign ctrl_o.emit  = col_p[0] & row_p[0];
  assign ctrl_o.store = col_p[0] & ~row_p[0];
  assign ctrl_o.last  = (REG_W'(row_p) == h_last) && (WW'(col_p) == w_last);
  assign ctrl_o.sum   = here;
  assign addr_o       = AW'(col_p >> 1);

endmodule

// ===== hdl/rgb_half_scale_box_filter_core.sv =====
// 2x2 box filter with half-scale decimation for raster RGB video.
//
// Channels:
//   pix_i  - source pixels in raster order, one transfer per pixel, with a
//            start_of_frame flag that restarts the row/column counters.
//   res_o  - decimated pixels, BGR byte order, frame_done on the last one.
//   cfg_i  - register writes (frame_width, frame_height); always ready.
//            Write only while the block is idle.
// Throughput: one pixel per clock while not stalled. The only state
//   shared between pixels is the column/row counters and the running
//   pair sum, both updated in the accept cycle; the line store is one
//   write or one read per pixel.
// Output path: line store read, then output register, after the pixel
//   that completes its 2x2 block. One result per four source pixels.
// Stall: the read result waits in a one-deep stage behind the output
//   register, so input keeps flowing while one result is pending; pix_i
//   ready drops only when both are full and res_o is not taken.
// Reset: counters and pair sum clear, width/height return to 640x480.
//   The line store is not cleared; it is always written on an even row
//   before the odd row below reads it.
module rgb_half_scale_box_filter_core #(
  parameter int unsigned MAX_WIDTH = 4096
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  rgbhs_pix_if.sink    pix_i,
  rgbhs_out_if.source  res_o,
  rgbhs_cfg_if.sink    cfg_i
);
  import rgbhs_pkg::*;

  localparam int unsigned DEPTH = MAX_WIDTH / 2;
  localparam int unsigned AW    = $clog2(DEPTH);

  logic [REG_W-1:0] frame_width_q, frame_height_q;

  raster_ctrl_t ctrl;
  lane_sum_t    px, above;
  logic [AW-1:0] addr;
  logic          accept, rd_en, wr_en;

  // Read stage
  logic      s1_valid_q, s1_valid_d, s1_adv;
  lane_sum_t s1_here_q;
  logic      s1_last_q;

  // Output register
  logic       out_valid_q, out_valid_d;
  logic [7:0] out_b_q, out_g_q, out_r_q;
  logic       out_done_q;
  logic [LANE_W:0] sum_r, sum_g, sum_b;

  // Configuration registers
  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frame_width_q  <= WIDTH_RESET;
      frame_height_q <= HEIGHT_RESET;
    end else if (cfg_i.valid) begin
      unique case (cfg_i.index)
        REG_FRAME_WIDTH:  frame_width_q  <= cfg_i.data;
        REG_FRAME_HEIGHT: frame_height_q <= cfg_i.data;
        default: ;
      endcase
    end
  end

  // Input side
  assign s1_adv      = !out_valid_q || res_o.ready;
  assign pix_i.ready = !s1_valid_q || s1_adv;
  assign accept      = pix_i.valid && pix_i.ready;

  assign px.red   = {1'b0, pix_i.red};
  assign px.green = {1'b0, pix_i.green};
  assign px.blue  = {1'b0, pix_i.blue};

  rgbhs_raster #(
    .MAX_WIDTH (MAX_WIDTH),
    .AW        (AW)
  ) u_raster (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .accept_i       (accept),
    .sof_i          (pix_i.start_of_frame),
    .px_i           (px),
    .frame_width_i  (frame_width_q),
    .frame_height_i (frame_height_q),
    .ctrl_o         (ctrl),
    .addr_o         (addr)
  );

  // Even rows write pair sums, odd rows read them back
  assign wr_en = accept && ctrl.store;
  assign rd_en = accept && ctrl.emit;

  rgbhs_line_store #(
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_line_store (
    .clk_i     (clk_i),
    .wr_en_i   (wr_en),
    .wr_addr_i (addr),
    .wr_data_i (ctrl.sum),
    .rd_en_i   (rd_en),
    .rd_addr_i (addr),
    .rd_data_o (above)
  );

  // Read stage: holds the lower pair while the store read completes
  always_comb begin
    if (accept) begin
      s1_valid_d = ctrl.emit;
    end else if (s1_adv) begin
      s1_valid_d = 1'b0;
    end else begin
      s1_valid_d = s1_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= s1_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en) begin
      s1_here_q <= ctrl.sum;
      s1_last_q <= ctrl.last;
    end
  end

  // Vertical add and divide by four
  assign sum_r = {1'b0, above.red}   + {1'b0, s1_here_q.red};
  assign sum_g = {1'b0, above.green} + {1'b0, s1_here_q.green};
  assign sum_b = {1'b0, above.blue}  + {1'b0, s1_here_q.blue};

  assign out_valid_d = s1_adv ? s1_valid_q : out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_adv && s1_valid_q) begin
      out_b_q    <= sum_b[LANE_W:2];
      out_g_q    <= sum_g[LANE_W:2];
      out_r_q    <= sum_r[LANE_W:2];
      out_done_q <= s1_last_q;
    end
  end

  // Red and blue swap places on the way out
  assign res_o.valid       = out_valid_q;
  assign res_o.first_byte  = out_b_q;
  assign res_o.middle_byte = out_g_q;
  assign res_o.third_byte  = out_r_q;
  assign res_o.frame_done  = out_done_q;

  // A store read must never overwrite data still waiting in the read stage
  a_no_read_while_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_valid_q && !s1_adv) |-> !rd_en)
    else $error("line store read while read stage is held");

  // Every read is followed by a valid read stage
  a_read_fills_stage: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rd_en |=> s1_valid_q)
    else $error("line store read lost");

  // A result leaving the read stage lands in the output register
  a_stage_to_output: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_valid_q && s1_adv) |=> out_valid_q)
    else $error("result dropped between read stage and output");

  // Write and read of the store never coincide
  a_store_one_port: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(wr_en && rd_en))
    else $error("line store written and read in the same cycle");

endmodule

// ===== sim/tb.sv =====
`timescale 1ns / 100ps

module tb;
  import rgbhs_pkg::*;

  localparam int unsigned MAX_W       = 4096;
  localparam int unsigned CYCLE_LIMIT = 1_000_000;
  // a pixel with no output may still be in flight
  localparam int unsigned DRAIN       = 8;
  localparam int unsigned HOLD_CYCLES = 400;

  typedef struct packed {
    logic       sof;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } src_pixel_t;

  // BGR order, same as the output channel
  typedef struct packed {
    logic [7:0] blue_avg;
    logic [7:0] green_avg;
    logic [7:0] red_avg;
    logic       done;
  } half_pixel_t;

  logic clk = 1'b0;
  logic rst_n;

  rgbhs_pix_if pix_bus ();
  rgbhs_out_if res_bus ();
  rgbhs_cfg_if cfg_bus ();

  rgb_half_scale_box_filter_core #(.MAX_WIDTH(MAX_W)) uut (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .pix_i  (pix_bus),
    .res_o  (res_bus),
    .cfg_i  (cfg_bus)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // --------------------------------------------------------------------
  // Downscaler state as the testbench sees it
  // --------------------------------------------------------------------
  logic [REG_W-1:0] width_reg;
  logic [REG_W-1:0] height_reg;
  logic [REG_W-1:0] col_pos;
  logic [REG_W-1:0] row_pos;
  lane_sum_t        pair_acc;
  // pair sums of the even row, read back by the odd row below it
  lane_sum_t        upper_pairs [MAX_W/2];

  src_pixel_t  src_pixels [$];    // pixels waiting for the driver
  half_pixel_t expected_out [$];  // predicted output pixels, oldest first

  int unsigned queued_cnt     = 0;
  int unsigned accepted_cnt   = 0;
  int unsigned cfg_cnt        = 0;
  int unsigned cycle_cnt      = 0;
  int unsigned err_cnt        = 0;
  int unsigned hold_left      = 0;
  int unsigned send_idle_pct  = 13;
  int unsigned recv_stall_pct = 77;
  logic        pix_took       = 1'b0;
  logic        hold_go        = 1'b0;
  logic        hold_done      = 1'b0;
  logic [REG_W-1:0] cfg_width = WIDTH_RESET;

  function automatic logic [REG_W-1:0] eff_dim(input logic [REG_W-1:0] v,
                                              input logic [REG_W-1:0] hi);
    if (v < DIM_MIN) return DIM_MIN;
    if (v > hi) return hi;
    return v;
  endfunction

  // lanes wrap at 9 bits; never reached with 8-bit pixels
  function automatic lane_sum_t lane_add(input lane_sum_t a, input lane_sum_t b);
    lane_sum_t s;
    s.red   = a.red + b.red;
    s.green = a.green + b.green;
    s.blue  = a.blue + b.blue;
    return s;
  endfunction

  // truncated mean of four values given as two pair sums
  function automatic logic [7:0] quarter(input logic [LANE_W-1:0] a,
                                         input logic [LANE_W-1:0] b);
    logic [LANE_W:0] s;
    s = a + b;
    return s[LANE_W:2];
  endfunction

  // Advance the raster position by one accepted pixel and queue the output
  // pixel it completes, if any.
  task automatic downscale_pixel(input src_pixel_t p);
    logic [REG_W-1:0] w;
    logic [REG_W-1:0] h;
    lane_sum_t        px;
    lane_sum_t        here;
    half_pixel_t      outp;
    w  = eff_dim(width_reg, REG_W'(MAX_W));
    h  = eff_dim(height_reg, HEIGHT_LIMIT);
    px = '{blue: {1'b0, p.blue}, green: {1'b0, p.green}, red: {1'b0, p.red}};

    if (p.sof) begin
      col_pos = '0;
      row_pos = '0;
    end
    // position left past the frame by a narrower setting
    if (col_pos >= w) begin
      col_pos = '0;
      row_pos++;
    end
    if (row_pos >= h) row_pos = '0;

    if (!col_pos[0]) begin
      pair_acc = px;
    end else if (!row_pos[0]) begin
      pair_acc = lane_add(pair_acc, px);
      upper_pairs[col_pos >> 1] = pair_acc;
    end else begin
      here           = lane_add(pair_acc, px);
      outp.blue_avg  = quarter(upper_pairs[col_pos >> 1].blue, here.blue);
      outp.green_avg = quarter(upper_pairs[col_pos >> 1].green, here.green);
      outp.red_avg   = quarter(upper_pairs[col_pos >> 1].red, here.red);
      // last odd row and last odd column; trailing odd ones are dropped
      outp.done      = (row_pos == (h & ~REG_W'(1)) - 1) &&
                       (col_pos == (w & ~REG_W'(1)) - 1);
      pair_acc       = here;
      expected_out.push_back(outp);
    end

    col_pos++;
    if (col_pos >= w) begin
      col_pos = '0;
      row_pos++;
      if (row_pos >= h) row_pos = '0;
    end
  endtask

  task automatic check_field(input string name, input logic [7:0] want,
                             input logic [7:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %0d actual %0d", $time, name, want, got);
      err_cnt++;
    end
  endtask

  // --------------------------------------------------------------------
  // Driver: changes inputs on the falling edge. A pixel stays on the bus
  // until its transfer has been seen at a rising edge.
  // --------------------------------------------------------------------
  always @(negedge clk) begin
    src_pixel_t nxt;
    if (rst_n && (!pix_bus.valid || pix_took)) begin
      if (src_pixels.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        nxt = src_pixels.pop_front();
        pix_bus.valid          <= 1'b1;
        pix_bus.start_of_frame <= nxt.sof;
        pix_bus.red            <= nxt.red;
        pix_bus.green          <= nxt.green;
        pix_bus.blue           <= nxt.blue;
      end else begin
        pix_bus.valid <= 1'b0;
      end
    end
    // long hold-off overrides the random stalls
    res_bus.ready <= rst_n && (hold_left == 0) && ($urandom_range(99) >= recv_stall_pct);
  end

  // Receiver hold-off, counted here so the sender keeps offering pixels
  // and the block has to back up into its input.
  always @(posedge clk) begin
    if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end else if (hold_go && !hold_done) begin
      hold_left <= HOLD_CYCLES;
      hold_done <= 1'b1;
    end
  end

  // --------------------------------------------------------------------
  // Monitor: every transfer is sampled at the rising edge. Input
  // transfers feed the predictor before outputs are checked.
  // --------------------------------------------------------------------
  always @(posedge clk) begin
    src_pixel_t  took;
    half_pixel_t got;
    half_pixel_t want;
    cycle_cnt++;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("%0t: timeout", $time);
      $display("FAIL");
      $finish;
    end else begin
      pix_took = pix_bus.valid && pix_bus.ready;
      if (pix_took) begin
        took = '{pix_bus.start_of_frame, pix_bus.red, pix_bus.green, pix_bus.blue};
        downscale_pixel(took);
        accepted_cnt++;
      end

      if (cfg_bus.valid && cfg_bus.ready) begin
        case (cfg_bus.index)
          REG_FRAME_WIDTH:  width_reg  = cfg_bus.data;
          REG_FRAME_HEIGHT: height_reg = cfg_bus.data;
          default: ;
        endcase
        cfg_cnt++;
      end

      if (res_bus.valid && res_bus.ready) begin
        got = '{res_bus.first_byte, res_bus.middle_byte, res_bus.third_byte,
                res_bus.frame_done};
        if (expected_out.size() == 0) begin
          $display("%0t: output pixel with nothing expected, actual %h", $time, got);
          err_cnt++;
        end else begin
          want = expected_out.pop_front();
          check_field("first_byte", want.blue_avg, got.blue_avg);
          check_field("middle_byte", want.green_avg, got.green_avg);
          check_field("third_byte", want.red_avg, got.red_avg);
          check_field("frame_done", 8'(want.done), 8'(got.done));
        end
      end
    end
  end

  // --------------------------------------------------------------------
  // Stimulus sequencing
  // --------------------------------------------------------------------

  // register write; only called with the block idle
  task automatic write_reg(input reg_idx_e idx, input logic [REG_W-1:0] val);
    int unsigned seen;
    @(negedge clk);
    seen = cfg_cnt;
    cfg_bus.valid <= 1'b1;
    cfg_bus.index <= idx;
    cfg_bus.data  <= val;
    do @(negedge clk); while (cfg_cnt == seen);
    cfg_bus.valid <= 1'b0;
  endtask

  // ends on a rising edge so the pixel queue is filled away from the driver
  task automatic set_frame(input logic [REG_W-1:0] w, input logic [REG_W-1:0] h);
    write_reg(REG_FRAME_WIDTH, w);
    write_reg(REG_FRAME_HEIGHT, h);
    cfg_width = w;
    @(posedge clk);
  endtask

  task automatic queue_pixel(input logic sof, input logic [7:0] r, g, b);
    src_pixels.push_back('{sof, r, g, b});
    queued_cnt++;
  endtask

  // all pixels taken, all outputs seen, then let the pipeline empty
  task automatic finish_phase();
    while (accepted_cnt != queued_cnt || expected_out.size() != 0) @(negedge clk);
    repeat (DRAIN) @(negedge clk);
  endtask

  // biased toward the channel extremes
  function automatic logic [7:0] rand_chan();
    case ($urandom_range(9))
      0:       return 8'h00;
      1:       return 8'hFF;
      default: return 8'($urandom);
    endcase
  endfunction

  // A phase of small random frames. A frame mostly opens with start of
  // frame; now and then it relies on the counter wrap, and a few stray
  // start-of-frame flags restart the frame midway. Widening the frame
  // forces a restart so the odd row never reads a pair sum from a row that
  // was never stored; narrowing may carry on mid-frame, which exercises
  // the past-the-frame wrap.
  task automatic random_phase(input int unsigned send_pct, input int unsigned recv_pct,
                              input logic do_hold);
    logic [REG_W-1:0] w_new;
    logic [REG_W-1:0] h_new;
    logic [REG_W-1:0] old_eff;
    int unsigned      n;
    int unsigned      frame_len;
    int unsigned      pos;
    logic             sof;
    old_eff = eff_dim(cfg_width, REG_W'(MAX_W));
    case ($urandom_range(9))
      0:       w_new = REG_W'($urandom_range(1));
      1:       w_new = REG_W'($urandom_range(13, 64));
      2:       w_new = $urandom_range(1) ? REG_W'(MAX_W) : '1;
      default: w_new = REG_W'($urandom_range(2, 12));
    endcase
    // narrow frame during the hold-off: enough outputs to back up the input
    if (do_hold) w_new = REG_W'($urandom_range(2, 6));
    case ($urandom_range(9))
      0:       h_new = REG_W'($urandom_range(1));
      1:       h_new = $urandom_range(1) ? HEIGHT_LIMIT : '1;
      default: h_new = REG_W'($urandom_range(2, 8));
    endcase
    set_frame(w_new, h_new);
    send_idle_pct  = send_pct;
    recv_stall_pct = recv_pct;

    frame_len = int'(eff_dim(w_new, REG_W'(MAX_W))) * int'(eff_dim(h_new, HEIGHT_LIMIT));
    n   = $urandom_range(22, 36);
    pos = 0;
    for (int i = 0; i < n; i++) begin
      if (i == 0)
        sof = (eff_dim(w_new, REG_W'(MAX_W)) > old_eff) || $urandom_range(1);
      else if (pos == 0)
        sof = ($urandom_range(3) != 0);
      else
        sof = ($urandom_range(39) == 0);
      if (sof) pos = 0;
      queue_pixel(sof, rand_chan(), rand_chan(), rand_chan());
      pos = (pos + 1) % frame_len;
    end

    if (do_hold) begin
      @(negedge clk);
      hold_go = 1'b1;
    end
    finish_phase();
  endtask

  initial begin
    rst_n                  = 1'b0;
    pix_bus.valid          = 1'b0;
    pix_bus.start_of_frame = 1'b0;
    pix_bus.red            = '0;
    pix_bus.green          = '0;
    pix_bus.blue           = '0;
    res_bus.ready          = 1'b0;
    cfg_bus.valid          = 1'b0;
    cfg_bus.index          = REG_FRAME_WIDTH;
    cfg_bus.data           = '0;
    width_reg              = WIDTH_RESET;
    height_reg             = HEIGHT_RESET;
    col_pos                = '0;
    row_pos                = '0;
    pair_acc               = '0;

    repeat (12) @(negedge clk);
    rst_n <= 1'b1;

    // Directed, 2x2 frames: one output each, always the last of its frame.
    // Distinct red and blue catch a missing byte swap.
    set_frame(13'd2, 13'd2);
    for (int i = 0; i < 4; i++) queue_pixel(i == 0, 8'hFF, 8'h00, 8'h80);
    // next frame follows the counter wrap, no start flag; sums truncate
    for (int i = 0; i < 4; i++) queue_pixel(1'b0, 8'(i >> 1), 8'hFF, 8'(i + 1));
    // start flag one pixel into a frame restarts it
    queue_pixel(1'b1, 8'd9, 8'd9, 8'd9);
    for (int i = 0; i < 4; i++) queue_pixel(i == 0, 8'hFF, 8'hFF, 8'hFF);
    finish_phase();

    // sizes below the minimum clamp up to 2x2
    set_frame(13'd1, 13'd0);
    for (int i = 0; i < 4; i++) queue_pixel(i == 0, 8'(10 + i), 8'(20 + i), 8'(30 + i));
    finish_phase();

    // odd size: trailing column and row give no output
    set_frame(13'd3, 13'd3);
    for (int i = 0; i < 9; i++) queue_pixel(i == 0, rand_chan(), rand_chan(), rand_chan());
    finish_phase();

    // Random frames: sender rarely idle with a slow receiver, then the
    // reverse, then both at full rate with one long receiver hold-off.
    for (int ph = 0; ph < 4; ph++) random_phase(13, 77, 1'b0);
    for (int ph = 0; ph < 4; ph++) random_phase(77, 13, 1'b0);
    for (int ph = 0; ph < 4; ph++) random_phase(0, 0, ph == 0);

    // Width over the limit clamps to the full line store; height at its
    // limit. A short run along the first row only fills pair sums.
    set_frame('1, HEIGHT_LIMIT);
    for (int i = 0; i < 48; i++)
      queue_pixel(i == 0, rand_chan(), rand_chan(), rand_chan());
    finish_phase();

    if (err_cnt == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

// ===== files.f =====
hdl/rgbhs_pkg.sv
hdl/rgbhs_if.sv
hdl/rgbhs_line_store.sv
hdl/rgbhs_raster.sv
hdl/rgb_half_scale_box_filter_core.sv
sim/tb.sv
